@@ hw/rtl/prws_pkg.sv @@
// ----------------------------------------------------------------------------
// prws_pkg
// Shared types and constants for the permutation random-walk step engine.
// ----------------------------------------------------------------------------
package prws_pkg;

   // Input opcodes
   typedef enum logic [1:0] {
      OP_WR_GEN     = 2'd0,
      OP_WR_CENTRAL = 2'd1,
      OP_START      = 2'd2,
      OP_STEP       = 2'd3
   } op_type;

   // Output word queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   // Fixed field widths of the ports
   localparam int IN_POS_BITS  = 4;
   localparam int IN_VAL_BITS  = 8;
   localparam int IN_GEN_BITS  = 4;
   localparam int OUT_POS_BITS = 4;
   localparam int OUT_EL_BITS  = 8;
   localparam int OUT_DST_BITS = 16;

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] out_position;
      logic [OUT_EL_BITS-1:0]  element;
      logic [OUT_DST_BITS-1:0] distance;
      logic                    last;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic wr_gen;
      logic wr_central;
      logic begin_walk;
      logic begin_step;
      logic issue;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic walk_active;
      logic room;
      logic last_issue;
      logic drained;
   } status_type;

endpackage

@@ hw/rtl/prws_ram.sv @@
// ----------------------------------------------------------------------------
// prws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/prws_ctrl.sv @@
// ----------------------------------------------------------------------------
// prws_ctrl
// Sequencer: takes input words, decodes the op and paces element issue.
// ----------------------------------------------------------------------------
module prws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   output prws_pkg::cmd_type    cmd,
   input  prws_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   prws_pkg::op_type  op;
   logic              accept;

   assign op        = prws_pkg::op_type'(req_op);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  prws_pkg::OP_WR_GEN:     cmd.wr_gen = 1'b1;
                  prws_pkg::OP_WR_CENTRAL: cmd.wr_central = 1'b1;
                  prws_pkg::OP_START: begin
                     cmd.begin_walk = 1'b1;
                     state_in       = ST_RUN;
                  end
                  prws_pkg::OP_STEP: begin
                     // a step with no walk under way is dropped
                     if (status.walk_active) begin
                        cmd.begin_step = 1'b1;
                        state_in       = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (status.room) begin
               cmd.issue = 1'b1;
               if (status.last_issue) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.drained) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/prws_dp.sv @@
// ----------------------------------------------------------------------------
// prws_dp
// Datapath: generator, central and state RAMs, element pipeline, output queue.
// ----------------------------------------------------------------------------
module prws_dp #(
   parameter int WALK_LEN  = 16,
   parameter int GEN_CNT   = 16,
   parameter int ELEM_BITS = 8,
   parameter int DIST_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prws_pkg::cmd_type                    cmd,
   output prws_pkg::status_type                 status,
   input  logic [prws_pkg::IN_GEN_BITS-1:0]     gen_sel,
   input  logic [prws_pkg::IN_POS_BITS-1:0]     position,
   input  logic [prws_pkg::IN_VAL_BITS-1:0]     value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output prws_pkg::rsp_word_type               rsp_word
);

   localparam int POS_W   = $clog2(WALK_LEN);
   localparam int CNT_W   = $clog2(WALK_LEN + 1);
   localparam int GEN_W   = (GEN_CNT > 1) ? $clog2(GEN_CNT) : 1;
   localparam int GDEPTH  = GEN_CNT * WALK_LEN;
   localparam int GADDR_W = $clog2(GDEPTH);
   localparam int GIN     = 1 << prws_pkg::IN_GEN_BITS;
   localparam int SIN     = 1 << prws_pkg::IN_POS_BITS;
   // two banks of a power-of-two size each, so {bank, position} always lands inside
   localparam int SDEPTH  = 2 * (1 << POS_W);

   // generator number wraps modulo the table size
   function automatic logic [GEN_W-1:0] gen_mod(input logic [prws_pkg::IN_GEN_BITS-1:0] g);
      logic [GEN_W-1:0] r;
      r = '0;
      for (int i = 0; i < GIN; i++) begin
         if (g == prws_pkg::IN_GEN_BITS'(i)) begin
            r = GEN_W'(i % GEN_CNT);
         end
      end
      return r;
   endfunction

   // stored source index wraps modulo the state size
   function automatic logic [POS_W-1:0] src_mod(input logic [prws_pkg::IN_POS_BITS-1:0] s);
      logic [POS_W-1:0] r;
      r = '0;
      for (int i = 0; i < SIN; i++) begin
         if (s == prws_pkg::IN_POS_BITS'(i)) begin
            r = POS_W'(i % WALK_LEN);
         end
      end
      return r;
   endfunction

   // walk state
   logic                 active_ff;
   logic                 active_in;
   logic [DIST_BITS-1:0] count_ff;
   logic [DIST_BITS-1:0] count_in;
   logic                 mode_step_ff;
   logic                 mode_step_in;
   logic [GEN_W-1:0]     gidx_ff;
   logic [GEN_W-1:0]     gidx_in;
   logic                 bank_ff;
   logic                 bank_in;
   logic [CNT_W-1:0]     k_ff;
   logic [CNT_W-1:0]     k_in;

   // element pipeline
   logic                 a_valid_ff;
   logic [POS_W-1:0]     a_k_ff;
   logic                 b_valid_ff;
   logic [POS_W-1:0]     b_k_ff;

   // output queue
   prws_pkg::rsp_word_type       fifo_ff [prws_pkg::FIFO_DEPTH];
   logic [prws_pkg::FIFO_AW-1:0] wr_ptr_ff;
   logic [prws_pkg::FIFO_AW-1:0] rd_ptr_ff;
   logic [prws_pkg::FIFO_CW-1:0] fill_ff;
   logic [prws_pkg::FIFO_CW-1:0] fill_in;
   logic [prws_pkg::FIFO_CW-1:0] busy_sum;

   // RAM ports
   logic [GEN_W-1:0]               wr_gidx;
   logic [63:0]                    pos64;
   logic [POS_W-1:0]               pos_idx;
   logic                           pos_ok;
   logic [GADDR_W-1:0]             gen_wr_addr;
   logic [GADDR_W-1:0]             gen_rd_addr;
   logic [prws_pkg::IN_POS_BITS-1:0] gen_rd_data;
   logic [63:0]                    val64;
   logic [ELEM_BITS-1:0]           central_rd_data;
   logic [ELEM_BITS-1:0]           state_rd_data;
   logic [POS_W:0]                 state_rd_addr;
   logic [POS_W:0]                 state_wr_addr;
   logic [ELEM_BITS-1:0]           elem;
   logic [63:0]                    elem64;
   logic [63:0]                    k64;
   logic [63:0]                    dist64;
   logic                           b_last;
   logic                           push;
   logic                           pop;
   prws_pkg::rsp_word_type         word;

   assign wr_gidx = gen_mod(gen_sel);
   assign pos64   = 64'(position);
   assign pos_idx = pos64[POS_W-1:0];
   assign pos_ok  = (int'(position) < WALK_LEN);
   assign val64   = 64'(value);

   assign gen_wr_addr = GADDR_W'(wr_gidx) * GADDR_W'(WALK_LEN) + GADDR_W'(pos_idx);
   assign gen_rd_addr = GADDR_W'(gidx_ff) * GADDR_W'(WALK_LEN) + GADDR_W'(k_ff[POS_W-1:0]);

   prws_ram #(
      .WIDTH (prws_pkg::IN_POS_BITS),
      .DEPTH (GDEPTH)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_gen && pos_ok),
      .wr_addr (gen_wr_addr),
      .wr_data (value[prws_pkg::IN_POS_BITS-1:0]),
      .rd_en   (cmd.issue),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   prws_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (WALK_LEN)
   ) u_central_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_central && pos_ok),
      .wr_addr (pos_idx),
      .wr_data (val64[ELEM_BITS-1:0]),
      .rd_en   (a_valid_ff),
      .rd_addr (a_k_ff),
      .rd_data (central_rd_data)
   );

   // two banks: read the old state from one, build the new one in the other
   assign state_rd_addr = {bank_ff, src_mod(gen_rd_data)};
   assign state_wr_addr = {~bank_ff, b_k_ff};

   prws_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (SDEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (state_wr_addr),
      .wr_data (elem),
      .rd_en   (a_valid_ff),
      .rd_addr (state_rd_addr),
      .rd_data (state_rd_data)
   );

   assign elem   = mode_step_ff ? state_rd_data : central_rd_data;
   assign elem64 = 64'(elem);
   assign k64    = 64'(b_k_ff);
   assign dist64 = 64'(count_ff);
   assign b_last = (b_k_ff == POS_W'(WALK_LEN - 1));

   always_comb begin
      word.out_position = k64[prws_pkg::OUT_POS_BITS-1:0];
      word.element      = elem64[prws_pkg::OUT_EL_BITS-1:0];
      word.distance     = dist64[prws_pkg::OUT_DST_BITS-1:0];
      word.last         = b_last;
   end

   assign push = b_valid_ff;
   assign pop  = rsp_valid && !rsp_stall;

   // walk control
   always_comb begin
      active_in    = active_ff;
      count_in     = count_ff;
      mode_step_in = mode_step_ff;
      gidx_in      = gidx_ff;
      bank_in      = bank_ff;
      k_in         = k_ff;
      if (cmd.begin_walk) begin
         active_in    = 1'b1;
         count_in     = '0;
         mode_step_in = 1'b0;
         k_in         = '0;
      end
      if (cmd.begin_step) begin
         mode_step_in = 1'b1;
         gidx_in      = wr_gidx;
         k_in         = '0;
         if (count_ff != '1) begin
            count_in = count_ff + DIST_BITS'(1);
         end
      end
      if (cmd.issue) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (push && b_last) begin
         bank_in = ~bank_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + prws_pkg::FIFO_CW'(1);
         2'b01:   fill_in = fill_ff - prws_pkg::FIFO_CW'(1);
         default: fill_in = fill_ff;
      endcase
   end

   assign busy_sum = fill_ff + prws_pkg::FIFO_CW'(a_valid_ff) + prws_pkg::FIFO_CW'(b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         count_ff   <= '0;
         bank_ff    <= 1'b0;
         k_ff       <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
      end else begin
         active_ff  <= active_in;
         count_ff   <= count_in;
         bank_ff    <= bank_in;
         k_ff       <= k_in;
         a_valid_ff <= cmd.issue;
         b_valid_ff <= a_valid_ff;
         fill_ff    <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + prws_pkg::FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + prws_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_step_ff <= mode_step_in;
      gidx_ff      <= gidx_in;
      a_k_ff       <= k_ff[POS_W-1:0];
      b_k_ff       <= a_k_ff;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= word;
      end
   end

   assign rsp_valid = (fill_ff != '0);
   assign rsp_word  = fifo_ff[rd_ptr_ff];

   always_comb begin
      status.walk_active = active_ff;
      status.room        = (busy_sum < prws_pkg::FIFO_CW'(prws_pkg::FIFO_DEPTH));
      status.last_issue  = (k_ff == CNT_W'(WALK_LEN - 1));
      status.drained     = !a_valid_ff && !b_valid_ff;
   end

endmodule

@@ hw/rtl/permutation_random_walk_step.sv @@
// ----------------------------------------------------------------------------
// permutation_random_walk_step
// Random walk over a Cayley graph generated by stored permutations.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  req      | req_valid/req_stall  | op, gen_sel, position, value
//  rsp      | rsp_valid/rsp_stall  | out_position, element, distance, last
//
//  Generator and central writes leave the sequencer idle for the next word.
//  A start or a step takes the word, makes WALK_LEN element issues (one a
//  cycle while the queue has room), then drains the generator-RAM then
//  state-RAM read chain before the next word is taken.
//  A 4-word output queue holds results; while rsp_stall is high the issue
//  pace drops to what the queue can take.
//  Synchronous reset clears the walk flag, distance, queue and sequencer.
//  Table stores are undefined until written and get no clearing pass.
//
module permutation_random_walk_step #(
   parameter int WALK_LEN  = 16,
   parameter int GEN_CNT   = 16,
   parameter int ELEM_BITS = 8,
   parameter int DIST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_gen_sel,
   input  logic [3:0]  req_position,
   input  logic [7:0]  req_value,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_out_position,
   output logic [7:0]  rsp_element,
   output logic [15:0] rsp_distance,
   output logic        rsp_last
);

   prws_pkg::cmd_type      ctrl_cmd;
   prws_pkg::status_type   dp_status;
   prws_pkg::rsp_word_type rsp_word;

   // sequencer: decodes ops and paces element issue
   prws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .cmd       (ctrl_cmd),
      .status    (dp_status)
   );

   // stores, element pipeline and output queue
   prws_dp #(
      .WALK_LEN  (WALK_LEN),
      .GEN_CNT   (GEN_CNT),
      .ELEM_BITS (ELEM_BITS),
      .DIST_BITS (DIST_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .gen_sel   (req_gen_sel),
      .position  (req_position),
      .value     (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_position = rsp_word.out_position;
   assign rsp_element      = rsp_word.element;
   assign rsp_distance     = rsp_word.distance;
   assign rsp_last         = rsp_word.last;

`ifndef ASSERT_OFF
   // a start always occupies the sequencer in the following cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == prws_pkg::OP_START) |=> req_stall)
      else $error("start did not occupy the sequencer");

   // a step with no walk under way is dropped at once
   a_step_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == prws_pkg::OP_STEP && !dp_status.walk_active)
      |=> !req_stall)
      else $error("idle step held the sequencer");

   // element issue only with queue room reserved
   a_issue_room: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.issue |-> dp_status.room)
      else $error("element issued without queue room");

   // last flag marks the final position
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_out_position == 4'(WALK_LEN - 1)))
      else $error("last flag on wrong position");
`endif

endmodule

@@ tb/prws_walk_tracker_pkg.sv @@
// ----------------------------------------------------------------------------
// prws_walk_tracker_pkg
// Tracks the walk engine's tables and walk state. Queues the words that each
// accepted request should produce and checks the words that come back.
// ----------------------------------------------------------------------------
package prws_walk_tracker_pkg;
   import prws_pkg::*;

   localparam int WALK_SIZE = 16;
   localparam int GEN_COUNT = 16;

   class walk_tracker;
      logic [3:0]   gen_src [GEN_COUNT][WALK_SIZE];
      logic [7:0]   central_elem [WALK_SIZE];
      logic [7:0]   walk_elem [WALK_SIZE];
      logic [15:0]  walk_dist;
      bit           walk_on;
      rsp_word_type pending_words [$];
      int unsigned  mismatches;

      function new();
         walk_dist  = '0;
         walk_on    = 1'b0;
         mismatches = 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      // One word per position, last flag on the final one
      function void queue_walk_state();
         rsp_word_type w;
         for (int k = 0; k < WALK_SIZE; k++) begin
            w.out_position = 4'(k);
            w.element      = walk_elem[k];
            w.distance     = walk_dist;
            w.last         = (k == WALK_SIZE - 1);
            pending_words.push_back(w);
         end
      endfunction

      function void take_request(input op_type op, input logic [3:0] gen,
                                 input logic [3:0] pos, input logic [7:0] value);
         logic [7:0] next_elem [WALK_SIZE];
         int         g;
         g = int'(gen) % GEN_COUNT;
         case (op)
            OP_WR_GEN: begin
               if (int'(pos) < WALK_SIZE) gen_src[g][pos] = value[3:0];
            end
            OP_WR_CENTRAL: begin
               if (int'(pos) < WALK_SIZE) central_elem[pos] = value;
            end
            OP_START: begin
               walk_elem = central_elem;
               walk_dist = '0;
               walk_on   = 1'b1;
               queue_walk_state();
            end
            OP_STEP: begin
               // ignored until a walk has been started
               if (walk_on) begin
                  for (int k = 0; k < WALK_SIZE; k++)
                     next_elem[k] = walk_elem[int'(gen_src[g][k]) % WALK_SIZE];
                  walk_elem = next_elem;
                  if (walk_dist != '1) walk_dist = walk_dist + 16'd1;
                  queue_walk_state();
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(input rsp_word_type got);
         rsp_word_type want;
         if (pending_words.size() == 0) begin
            $error("unexpected word: out_position %0d element %0h distance %0d last %0b",
                   got.out_position, got.element, got.distance, got.last);
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         if (got.out_position !== want.out_position) begin
            $error("out_position: expected %0d, actual %0d",
                   want.out_position, got.out_position);
            mismatches++;
         end
         if (got.element !== want.element) begin
            $error("element: expected %0h, actual %0h", want.element, got.element);
            mismatches++;
         end
         if (got.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the permutation random-walk step engine. Preloads
// every table entry, runs a short directed sequence, fills the output queue
// behind a long receiver hold-off, then drives random walks with random
// idling on both channels and a final stretch with none.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import prws_pkg::*;
   import prws_walk_tracker_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int LONG_HOLD      = 200;   // receiver hold-off, cycles
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with nothing accepted
   localparam int DRAIN_CYCLES   = WALK_SIZE + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [3:0]  req_gen_sel = '0;
   logic [3:0]  req_position = '0;
   logic [7:0]  req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_out_position;
   logic [7:0]  rsp_element;
   logic [15:0] rsp_distance;
   logic        rsp_last;

   walk_tracker tracker = new();

   bit          idling_on = 1'b0;
   bit          long_hold_pending = 1'b0;
   int unsigned words_sent = 0;
   int unsigned quiet_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   permutation_random_walk_step i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_gen_sel      (req_gen_sel),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_position (rsp_out_position),
      .rsp_element      (rsp_element),
      .rsp_distance     (rsp_distance),
      .rsp_last         (rsp_last)
   );

   // -------------------------------------------------------------------------
   // Sender. Payload changes on the falling edge only; once offered, a word
   // stays put until the rising edge at which req_stall is low. An optional
   // gap with req_valid low goes in front of the word while idling is enabled.
   // -------------------------------------------------------------------------
   task automatic send_word(input op_type op, input logic [3:0] gen,
                            input logic [3:0] pos, input logic [7:0] value);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_gen_sel  <= gen;
      req_position <= pos;
      req_value    <= value;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Writes a whole generator row: a shuffled permutation with junk in the
   // upper nibble (masked by the block), or fully arbitrary source indexes.
   task automatic write_gen_row(input logic [3:0] gen, input bit arbitrary);
      logic [3:0] perm [WALK_SIZE];
      logic [3:0] swap;
      int         j;
      for (int k = 0; k < WALK_SIZE; k++) perm[k] = 4'(k);
      for (int k = WALK_SIZE - 1; k > 0; k--) begin
         j       = $urandom_range(0, k);
         swap    = perm[k];
         perm[k] = perm[j];
         perm[j] = swap;
      end
      for (int k = 0; k < WALK_SIZE; k++)
         send_word(OP_WR_GEN, gen, 4'(k),
                   arbitrary ? 8'($urandom) : {4'($urandom), perm[k]});
   endtask

   // A start followed by a number of steps through random generators. The
   // unused fields carry random junk, which the block must disregard.
   task automatic run_walk(input int unsigned steps);
      send_word(OP_START, 4'($urandom), 4'($urandom), 8'($urandom));
      repeat (steps) send_word(OP_STEP, 4'($urandom), 4'($urandom), 8'($urandom));
   endtask

   // Mostly walks of random length; now and then rows or central elements
   // get rewritten between walks.
   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      int          pick;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(0, 15);
         if (pick == 0)
            write_gen_row(4'($urandom), $urandom_range(0, 2) == 0);
         else if (pick <= 2)
            repeat ($urandom_range(1, 4))
               send_word(OP_WR_CENTRAL, 4'($urandom), 4'($urandom), 8'($urandom));
         else
            run_walk($urandom_range(0, 10));
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver. Random stall bursts while idling is enabled; a one-off long
   // hold-off when requested, so the output queue fills and the block has
   // to push back on the sender.
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: both channels sampled on the rising edge. Requests feed the
   // tracker, responses are checked against the oldest queued word. The
   // watchdog counts cycles with nothing accepted on either side.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type seen;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            tracker.take_request(op_type'(req_op), req_gen_sel, req_position, req_value);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen.out_position = rsp_out_position;
            seen.element      = rsp_element;
            seen.distance     = rsp_distance;
            seen.last         = rsp_last;
            tracker.check_word(seen);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // Preload: every central element and every generator row, so no start
      // or step ever reads an entry that was never written.
      for (int k = 0; k < WALK_SIZE; k++)
         send_word(OP_WR_CENTRAL, 4'($urandom), 4'(k), 8'($urandom));
      for (int g = 0; g < GEN_COUNT; g++)
         write_gen_row(4'(g), 1'b0);

      // Directed: step with no walk running must be dropped silently
      send_word(OP_STEP, 4'hf, 4'h0, 8'h00);
      // element value extremes
      send_word(OP_WR_CENTRAL, 4'h0, 4'h0, 8'h00);
      send_word(OP_WR_CENTRAL, 4'hf, 4'hf, 8'hff);
      // source index masking: upper nibble must be discarded
      send_word(OP_WR_GEN, 4'hf, 4'h0, 8'hff);
      send_word(OP_WR_GEN, 4'hf, 4'hf, 8'hf0);
      send_word(OP_START, 4'h0, 4'h0, 8'h00);
      send_word(OP_STEP, 4'h0, 4'h0, 8'h00);
      send_word(OP_STEP, 4'hf, 4'hf, 8'hff);
      send_word(OP_STEP, 4'hf, 4'h0, 8'h00);
      // restart clears the distance
      send_word(OP_START, 4'hf, 4'hf, 8'hff);
      send_word(OP_STEP, 4'h7, 4'h8, 8'h5a);
      // central write mid-walk: current state untouched until next start
      send_word(OP_WR_CENTRAL, 4'h0, 4'h3, 8'ha5);
      send_word(OP_STEP, 4'h3, 4'h0, 8'h00);
      send_word(OP_START, 4'h0, 4'h0, 8'h00);

      // Back-pressure: receiver holds off while a walk is pushed in
      // back-to-back, filling the output queue.
      idling_on = 1'b0;
      long_hold_pending = 1'b1;
      run_walk(6);
      idling_on = 1'b1;

      run_random(40);

      // last stretch at full rate
      idling_on = 1'b0;
      run_random(15);

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/prws_pkg.sv
hw/rtl/prws_ram.sv
hw/rtl/prws_ctrl.sv
hw/rtl/prws_dp.sv
hw/rtl/permutation_random_walk_step.sv
tb/prws_walk_tracker_pkg.sv
tb/tb_top.sv
